>>> rtl/drive_safety_function_monitor_core_assert.svh
// Assertion macros for the checker module of this block.
`ifndef DRIVE_SAFETY_FUNCTION_MONITOR_CORE_ASSERT_SVH
`define DRIVE_SAFETY_FUNCTION_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DSFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/dsfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dsfm_pkg;

    // Field widths.
    localparam int POSITION_BITS  = 32;
    localparam int SPEED_BITS     = 24;
    localparam int WINDOW_BITS    = 31;
    localparam int TIME_BITS      = 64;
    localparam int ACTION_BITS    = 3;
    localparam int MODE_BITS      = 3;
    localparam int FAULT_BITS     = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Operating modes.
    typedef enum logic [MODE_BITS-1:0] {
        MODE_SELF_TEST = 3'd0,
        MODE_STO       = 3'd1,
        MODE_SS1       = 3'd2,
        MODE_SOS       = 3'd3,
        MODE_SLS       = 3'd4,
        MODE_OPER      = 3'd5
    } mode_t;

    // Fault causes.
    typedef enum logic [FAULT_BITS-1:0] {
        FAULT_NONE       = 4'd0,
        FAULT_ESTOP      = 4'd1,
        FAULT_COMM       = 4'd2,
        FAULT_WATCHDOG   = 4'd3,
        FAULT_SPEED      = 4'd4,
        FAULT_POSITION   = 4'd5,
        FAULT_STANDSTILL = 4'd6,
        FAULT_STOP_TIME  = 4'd7,
        FAULT_INVALID    = 4'd8
    } fault_t;

    // Requested safety functions.
    localparam logic [ACTION_BITS-1:0] ACT_RUN = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_STO = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_SS1 = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_SOS = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_SLS = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLS_CEILING       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STILL_THRESHOLD   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_WINDOW       = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_TIME_LIMIT   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POS_FLOOR         = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POS_CEILING       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_POSITION_WATCH_ON = 3'd6;

    typedef struct packed {
        logic                            estop;
        logic                            link_ok;
        logic                            heartbeat_good;
        logic                            ack;
        logic                            selftest_ok;
        logic [SPEED_BITS-1:0]           speed_mag;
        logic signed [POSITION_BITS-1:0] pos;
        logic [TIME_BITS-1:0]            now_ns;
        logic [ACTION_BITS-1:0]          action;
    } in_item_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]  mode_out;
        logic [FAULT_BITS-1:0] fault_code;
        logic                  fault_held;
        logic                  torque_ok;
        logic                  motion_ok;
        logic [SPEED_BITS-1:0] speed_cap;
        logic                  speed_unlimited;
        logic                  brake_on;
    } out_item_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0]           sls_ceiling;
        logic [SPEED_BITS-1:0]           still_threshold;
        logic [WINDOW_BITS-1:0]          hold_window;
        logic [TIME_BITS-1:0]            stop_time_limit;
        logic signed [POSITION_BITS-1:0] pos_floor;
        logic signed [POSITION_BITS-1:0] pos_ceiling;
        logic                            position_watch_on;
    } cfg_t;

    typedef struct packed {
        mode_t                           mode;
        fault_t                          fault;
        logic [TIME_BITS-1:0]            stop_start_time;
        logic signed [POSITION_BITS-1:0] hold_position;
    } state_t;

endpackage

`default_nettype wire

>>> rtl/dsfm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfm_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [dsfm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dsfm_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output dsfm_pkg::cfg_t                       cfg
);
    import dsfm_pkg::*;

    cfg_t cfg_reg;

    // Register file; writes to an index past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sls_ceiling       <= '0;
            cfg_reg.still_threshold   <= '0;
            cfg_reg.hold_window       <= '0;
            cfg_reg.stop_time_limit   <= '0;
            cfg_reg.pos_floor         <= {1'b1, {(POSITION_BITS-1){1'b0}}};
            cfg_reg.pos_ceiling       <= {1'b0, {(POSITION_BITS-1){1'b1}}};
            cfg_reg.position_watch_on <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SLS_CEILING:
                    cfg_reg.sls_ceiling <= cfg_data[SPEED_BITS-1:0];
                REG_STILL_THRESHOLD:
                    cfg_reg.still_threshold <= cfg_data[SPEED_BITS-1:0];
                REG_HOLD_WINDOW:
                    cfg_reg.hold_window <= cfg_data[WINDOW_BITS-1:0];
                REG_STOP_TIME_LIMIT:
                    cfg_reg.stop_time_limit <= cfg_data[TIME_BITS-1:0];
                REG_POS_FLOOR:
                    cfg_reg.pos_floor <= $signed(cfg_data[POSITION_BITS-1:0]);
                REG_POS_CEILING:
                    cfg_reg.pos_ceiling <= $signed(cfg_data[POSITION_BITS-1:0]);
                REG_POSITION_WATCH_ON:
                    cfg_reg.position_watch_on <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/dsfm_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module dsfm_eval (
    input  dsfm_pkg::cfg_t      cfg,
    input  dsfm_pkg::state_t    st,
    input  dsfm_pkg::in_item_t  item,
    output dsfm_pkg::state_t    st_next,
    output dsfm_pkg::out_item_t res
);
    import dsfm_pkg::*;

    logic                          demand_stop;
    fault_t                        demand_cause;
    logic signed [POSITION_BITS:0] pos_diff;
    logic [POSITION_BITS:0]        pos_dev;
    logic                          window_bad;
    logic [TIME_BITS-1:0]          elapsed;
    logic                          over_limit;
    logic                          still;
    logic                          out_of_range;
    logic                          done;
    logic                          safe_off;

    // Unconditional stop demands and their cause, first match wins.
    assign demand_stop  = item.estop || !item.link_ok || !item.heartbeat_good;
    assign demand_cause = item.estop ? FAULT_ESTOP
                        : (!item.link_ok ? FAULT_COMM : FAULT_WATCHDOG);

    // Deviation from the standstill reference, as a magnitude one bit wider.
    assign pos_diff   = $signed({item.pos[POSITION_BITS-1], item.pos})
                      - $signed({st.hold_position[POSITION_BITS-1], st.hold_position});
    assign pos_dev    = pos_diff[POSITION_BITS] ? (~pos_diff + 1'b1) : pos_diff;
    assign window_bad = pos_dev > {{(POSITION_BITS + 1 - WINDOW_BITS){1'b0}},
                                   cfg.hold_window};

    // Stop time wraps around the time stamp width.
    assign elapsed    = item.now_ns - st.stop_start_time;
    assign over_limit = elapsed > cfg.stop_time_limit;

    assign still        = item.speed_mag <= cfg.still_threshold;
    assign out_of_range = ($signed(item.pos) < $signed(cfg.pos_floor))
                       || ($signed(item.pos) > $signed(cfg.pos_ceiling));

    // Monitors in fixed precedence, then the requested transition.
    always_comb
    begin
        st_next = st;
        done    = 1'b0;

        if (demand_stop)
        begin
            st_next.mode = MODE_STO;
            if (st.fault == FAULT_NONE)
            begin
                st_next.fault = demand_cause;
            end
            done = 1'b1;
        end
        else if (st.fault != FAULT_NONE)
        begin
            if (item.ack)
            begin
                st_next.fault = FAULT_NONE;
            end
            st_next.mode = MODE_STO;
            done = 1'b1;
        end
        else
        begin
            // Per-mode monitors; a violated limit latches its fault and forces STO.
            case (st.mode)
                MODE_SELF_TEST:
                begin
                    if (item.selftest_ok)
                    begin
                        st_next.mode = MODE_STO;
                    end
                    done = 1'b1;
                end
                MODE_SLS:
                begin
                    if (item.speed_mag > cfg.sls_ceiling)
                    begin
                        st_next.mode  = MODE_STO;
                        st_next.fault = FAULT_SPEED;
                        done = 1'b1;
                    end
                end
                MODE_SOS:
                begin
                    if (window_bad || !still)
                    begin
                        st_next.mode  = MODE_STO;
                        st_next.fault = FAULT_STANDSTILL;
                        done = 1'b1;
                    end
                end
                MODE_SS1:
                begin
                    if (still)
                    begin
                        st_next.mode = MODE_STO;
                    end
                    else if (over_limit)
                    begin
                        st_next.mode  = MODE_STO;
                        st_next.fault = FAULT_STOP_TIME;
                    end
                    done = 1'b1;
                end
                default:
                begin
                end
            endcase

            // Limited position monitor in the motion modes.
            if (!done && cfg.position_watch_on
                && (st.mode == MODE_OPER || st.mode == MODE_SLS) && out_of_range)
            begin
                st_next.mode  = MODE_STO;
                st_next.fault = FAULT_POSITION;
                done = 1'b1;
            end

            if (!done)
            begin
                unique case (item.action)
                    ACT_STO:
                        st_next.mode = MODE_STO;
                    ACT_SS1:
                    begin
                        if (st.mode == MODE_OPER || st.mode == MODE_SLS
                            || st.mode == MODE_SOS)
                        begin
                            st_next.mode            = MODE_SS1;
                            st_next.stop_start_time = item.now_ns;
                        end
                    end
                    ACT_SOS:
                    begin
                        if (st.mode == MODE_OPER || st.mode == MODE_SLS)
                        begin
                            if (!still)
                            begin
                                st_next.mode  = MODE_STO;
                                st_next.fault = FAULT_INVALID;
                            end
                            else
                            begin
                                st_next.mode          = MODE_SOS;
                                st_next.hold_position = item.pos;
                            end
                        end
                        else if (st.mode == MODE_STO)
                        begin
                            st_next.fault = FAULT_INVALID;
                        end
                    end
                    ACT_SLS:
                    begin
                        if (st.mode == MODE_STO || st.mode == MODE_OPER
                            || st.mode == MODE_SOS)
                        begin
                            if (item.speed_mag > cfg.sls_ceiling)
                            begin
                                st_next.mode  = MODE_STO;
                                st_next.fault = FAULT_SPEED;
                            end
                            else
                            begin
                                st_next.mode = MODE_SLS;
                            end
                        end
                    end
                    ACT_RUN:
                    begin
                        if (st.mode == MODE_STO || st.mode == MODE_SLS
                            || st.mode == MODE_SOS)
                        begin
                            st_next.mode = MODE_OPER;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Permissions and limits follow the new mode and fault.
    assign safe_off = (st_next.mode == MODE_SELF_TEST) || (st_next.mode == MODE_STO);

    always_comb
    begin
        res.mode_out        = st_next.mode;
        res.fault_code      = st_next.fault;
        res.fault_held      = st_next.fault != FAULT_NONE;
        res.torque_ok       = !safe_off;
        res.motion_ok       = (st_next.mode == MODE_SLS) || (st_next.mode == MODE_OPER);
        res.speed_cap       = (st_next.mode == MODE_SLS) ? cfg.sls_ceiling : '0;
        res.speed_unlimited = st_next.mode == MODE_OPER;
        res.brake_on        = safe_off;
    end

endmodule

`default_nettype wire

>>> rtl/drive_safety_function_monitor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Drive safety function monitor: each input transfer is one control cycle of
// measurements and a requested function (STO, SS1, SOS, SLS or unrestricted);
// each output transfer reports the resulting mode, the latched first fault,
// torque and motion permissions, brake and speed limit. The block takes one
// item per clock while the output is not stalled: an item is held in the input
// register, is evaluated against the mode and fault registers, and is loaded
// into the result register when the result register has room. A stalled
// output holds both registers and drops the input ready while the input
// register is full. The mode, fault, stop start time and hold position update
// in the same cycle an item moves to the result register, which keeps items
// strictly in order. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no item is in
// flight, and the block itself does not enforce this. Reset leaves the block in
// self test with the brake engaged.
module drive_safety_function_monitor_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dsfm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dsfm_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [dsfm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dsfm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import dsfm_pkg::*;

    cfg_t      cfg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    state_t    state_reg;
    state_t    state_next;
    out_item_t res_next;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      out_free;
    logic      s1_advance;

    dsfm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dsfm_eval u_eval (
        .cfg     (cfg),
        .st      (state_reg),
        .item    (s1_item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Flow control: each stage moves when the one after it has room.
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_ready   = !s1_valid_reg || out_free;

    // Valid bits and the safety state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            state_reg.mode            <= MODE_SELF_TEST;
            state_reg.fault           <= FAULT_NONE;
            state_reg.stop_start_time <= '0;
            state_reg.hold_position   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
        if (s1_advance)
        begin
            out_item_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

`default_nettype wire

>>> rtl/dsfm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "drive_safety_function_monitor_core_assert.svh"

module dsfm_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire dsfm_pkg::out_item_t out_data
);
    import dsfm_pkg::*;

    // A stalled result holds until its transfer.
    `DSFM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // Torque permission and brake are always complementary.
    `DSFM_ASSERT_NOW(a_torque_brake, clk, rst_n, out_valid, out_data.torque_ok != out_data.brake_on)

    // A latched fault always keeps the drive in STO.
    `DSFM_ASSERT_NOW(a_fault_sto, clk, rst_n, out_valid && out_data.fault_held, out_data.mode_out == MODE_STO && out_data.fault_code != FAULT_NONE)

    // Unlimited speed only in operational mode, with no cap reported.
    `DSFM_ASSERT_NOW(a_unlimited, clk, rst_n, out_valid && out_data.speed_unlimited, out_data.mode_out == MODE_OPER && out_data.speed_cap == '0)

endmodule

bind drive_safety_function_monitor_core dsfm_checker u_dsfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
